// ===== hw/rtl/tmlhp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmlhp_pkg
// Shared types, character codes and limits for the monitor line header parser.
// ----------------------------------------------------------------------------
package tmlhp_pkg;

    // line limits
    localparam int CALL_LEN = 6;
    localparam int MAX_PATH = 8;
    localparam int MAX_INFO = 256;

    localparam int CALL_CNT_W = $clog2(CALL_LEN + 1);
    localparam int INFO_CNT_W = $clog2(MAX_INFO + 1);
    localparam int PATH_CNT_W = 4;

    // callsign field: six bytes, first character in the top byte
    localparam int CALL_BYTES = 6;
    localparam int CALL_W     = 8 * CALL_BYTES;
    localparam logic [CALL_W-1:0] PAD_ALL = {CALL_BYTES{8'h20}};

    localparam int SSID_W   = 4;
    localparam int SSID_MAX = 15;

    // character codes
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 2;

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    typedef enum logic [1:0] {
        KIND_ADDR   = 2'd0,
        KIND_INFO   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ROLE_SRC  = 2'd0,
        ROLE_DEST = 2'd1,
        ROLE_PATH = 2'd2
    } role_t;

    typedef struct packed {
        kind_t              kind;
        role_t              role;
        logic [2:0]         path_slot;
        logic [CALL_W-1:0]  callsign;
        logic [SSID_W-1:0]  ssid;
        logic               repeated;
        logic [7:0]         info_byte;
        logic               status;
        logic               run_last;
    } result_t;

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

// ===== hw/rtl/tmlhp_parse.sv =====
// ----------------------------------------------------------------------------
// tmlhp_parse
// Per-byte parser state and result generation; up to two results per byte.
// ----------------------------------------------------------------------------
module tmlhp_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          text_byte,
    input  logic                line_end,
    output tmlhp_pkg::result_t  res0,
    output tmlhp_pkg::result_t  res1,
    output logic [1:0]          res_count
);
    import tmlhp_pkg::*;

    typedef enum logic [3:0] {
        PH_CALL = 4'b0001,
        PH_SSID = 4'b0010,
        PH_STAR = 4'b0100,
        PH_INFO = 4'b1000
    } phase_t;

    phase_t                  phase_reg, phase_next;
    role_t                   role_reg, role_next;
    logic [CALL_W-1:0]       call_reg, call_next;
    logic [CALL_CNT_W-1:0]   ccnt_reg, ccnt_next;
    logic [SSID_W-1:0]       ssid_reg, ssid_next;
    logic                    seen_reg, seen_next;
    logic                    star_reg, star_next;
    logic [PATH_CNT_W-1:0]   path_reg, path_next;
    logic [INFO_CNT_W-1:0]   info_reg, info_next;
    logic                    failed_reg, failed_next;

    result_t                 hres, sres;
    logic                    hvalid;
    logic                    do_end;
    logic                    brk;
    logic                    digit;
    logic [7:0]              ssid_ext;
    logic [7:0]              ssid_sum;

    assign brk = (text_byte == CH_DASH) || (text_byte == CH_STAR) ||
                 (text_byte == CH_COMMA) || (text_byte == CH_GT) ||
                 (text_byte == CH_COLON);
    assign digit    = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign ssid_ext = {4'b0, ssid_reg};
    assign ssid_sum = (ssid_ext << 3) + (ssid_ext << 1) + {4'b0, text_byte[3:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        role_next   = role_reg;
        call_next   = call_reg;
        ccnt_next   = ccnt_reg;
        ssid_next   = ssid_reg;
        seen_next   = seen_reg;
        star_next   = star_reg;
        path_next   = path_reg;
        info_next   = info_reg;
        failed_next = failed_reg;
        hres        = '0;
        sres        = '0;
        hvalid      = 1'b0;
        do_end      = 1'b0;
        res0        = '0;
        res1        = '0;
        res_count   = 2'd0;

        if (!failed_reg)
        begin
            unique case (phase_reg)
                PH_INFO:
                begin
                    if (info_reg >= INFO_CNT_W'(MAX_INFO))
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        info_next      = info_reg + 1'b1;
                        hvalid         = 1'b1;
                        hres.kind      = KIND_INFO;
                        hres.info_byte = text_byte;
                    end
                end
                PH_CALL:
                begin
                    if (text_byte < CH_SPACE || text_byte >= CH_DEL)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (!brk)
                    begin
                        if (!is_alnum(text_byte) || ccnt_reg >= CALL_CNT_W'(CALL_LEN))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            // a character past the sixth fails the line
                            for (int i = 0; i < CALL_BYTES; i++)
                            begin
                                if (i < CALL_LEN && ccnt_reg == CALL_CNT_W'(i))
                                begin
                                    call_next[8*(CALL_BYTES-1-i) +: 8] = text_byte;
                                end
                            end
                            ccnt_next = ccnt_reg + 1'b1;
                        end
                    end
                    else if (ccnt_reg == '0)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (text_byte == CH_DASH)
                    begin
                        phase_next = PH_SSID;
                    end
                    else if (text_byte == CH_STAR)
                    begin
                        star_next  = 1'b1;
                        phase_next = PH_STAR;
                    end
                    else
                    begin
                        do_end = 1'b1;
                    end
                end
                PH_SSID:
                begin
                    if (digit)
                    begin
                        if (ssid_sum > 8'(SSID_MAX))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            ssid_next = ssid_sum[SSID_W-1:0];
                            seen_next = 1'b1;
                        end
                    end
                    else if (!seen_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (text_byte == CH_STAR)
                    begin
                        star_next  = 1'b1;
                        phase_next = PH_STAR;
                    end
                    else
                    begin
                        do_end = 1'b1;
                    end
                end
                PH_STAR:
                begin
                    do_end = 1'b1;
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase

            // delimiter closing an address
            if (do_end)
            begin
                if ((role_reg == ROLE_SRC) ? (text_byte != CH_GT)
                        : (text_byte != CH_COMMA && text_byte != CH_COLON))
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    hvalid         = 1'b1;
                    hres.kind      = KIND_ADDR;
                    hres.role      = role_reg;
                    hres.path_slot = (role_reg == ROLE_PATH) ? path_reg[2:0] : 3'd0;
                    hres.callsign  = call_reg;
                    hres.ssid      = ssid_reg;
                    hres.repeated  = star_reg;
                    if (role_reg == ROLE_PATH)
                    begin
                        path_next = path_reg + 1'b1;
                    end
                    phase_next = PH_CALL;
                    call_next  = PAD_ALL;
                    ccnt_next  = '0;
                    ssid_next  = '0;
                    seen_next  = 1'b0;
                    star_next  = 1'b0;
                    if (text_byte == CH_GT)
                    begin
                        role_next = ROLE_DEST;
                    end
                    else if (text_byte == CH_COMMA)
                    begin
                        role_next = ROLE_PATH;
                        if (path_next >= PATH_CNT_W'(MAX_PATH))
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_INFO;
                    end
                end
            end
        end

        if (hvalid)
        begin
            res0      = hres;
            res_count = 2'd1;
        end

        if (line_end)
        begin
            sres.kind   = KIND_STATUS;
            sres.status = failed_next || (phase_next != PH_INFO);
            if (hvalid)
            begin
                res1      = sres;
                res_count = 2'd2;
            end
            else
            begin
                res0      = sres;
                res_count = 2'd1;
            end
            phase_next  = PH_CALL;
            role_next   = ROLE_SRC;
            call_next   = PAD_ALL;
            ccnt_next   = '0;
            ssid_next   = '0;
            seen_next   = 1'b0;
            star_next   = 1'b0;
            path_next   = '0;
            info_next   = '0;
            failed_next = 1'b0;
        end

        if (res_count == 2'd2)
        begin
            res1.run_last = 1'b1;
        end
        else if (res_count == 2'd1)
        begin
            res0.run_last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CALL;
            role_reg   <= ROLE_SRC;
            call_reg   <= PAD_ALL;
            ccnt_reg   <= '0;
            ssid_reg   <= '0;
            seen_reg   <= 1'b0;
            star_reg   <= 1'b0;
            path_reg   <= '0;
            info_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            role_reg   <= role_next;
            call_reg   <= call_next;
            ccnt_reg   <= ccnt_next;
            ssid_reg   <= ssid_next;
            seen_reg   <= seen_next;
            star_reg   <= star_next;
            path_reg   <= path_next;
            info_reg   <= info_next;
            failed_reg <= failed_next;
        end
    end

endmodule

// ===== hw/rtl/tmlhp_outq.sv =====
// ----------------------------------------------------------------------------
// tmlhp_outq
// Small result queue: takes up to two results per cycle, gives out one.
// ----------------------------------------------------------------------------
module tmlhp_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_count,
    input  tmlhp_pkg::result_t  push0,
    input  tmlhp_pkg::result_t  push1,
    output logic                room,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tmlhp_pkg::result_t  head
);
    import tmlhp_pkg::*;

    result_t              q_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wr_ptr_reg;
    logic [OUTQ_AW-1:0]   rd_ptr_reg;
    logic [OUTQ_CW-1:0]   cnt_reg;
    logic                 pop;

    // room for a full pair of results
    assign room      = cnt_reg <= OUTQ_CW'(OUTQ_DEPTH - 2);
    assign pop_valid = cnt_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign head      = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            q_mem[wr_ptr_reg + 1'b1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + OUTQ_AW'(push_count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + OUTQ_CW'(push_count) - OUTQ_CW'(pop);
        end
    end

endmodule

// ===== hw/rtl/text_monitor_line_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// text_monitor_line_header_parser_core
// Splits a monitor line SRC>DEST,PATH...:info into address records, info
// bytes and an end status.
//
// channel  dir  tdata                        tuser    tlast
// s_axis   in   text_byte                    -        line_end
// m_axis   out  role..status (see port)      kind     run_last
//
// one input byte per cycle while s_tready is high; the state update and
// results are formed in the accepting cycle and written into the queue.
// a byte yielding two results (record plus end status) is given out as
// two transfers; the four-entry result queue holds them and s_tready drops
// only when fewer than two entries are free. reset is asynchronous, active
// low, and clears the parser to the start of a line and empties the queue.
// ----------------------------------------------------------------------------
module text_monitor_line_header_parser_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tmlhp_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] text_byte
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] role, [4:2] path_slot, [52:5] callsign, [56:53] ssid,
    // [57] repeated, [65:58] info_byte, [66] status, rest zero
    output logic [tmlhp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [tmlhp_pkg::OUT_TUSER_W-1:0]    m_tuser,  // [1:0] kind
    output logic                                 m_tlast
);
    import tmlhp_pkg::*;

    logic       accept;
    logic       room;
    result_t    res0, res1, head;
    logic [1:0] res_count;
    logic [1:0] push_count;

    assign s_tready   = room;
    assign accept     = s_tvalid && room;
    assign push_count = accept ? res_count : 2'd0;

    tmlhp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (s_tdata),
        .line_end  (s_tlast),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    tmlhp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .head       (head)
    );

    assign m_tdata = {5'b0, head.status, head.info_byte, head.repeated, head.ssid,
                      head.callsign, head.path_slot, head.role};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_last;

endmodule
